// ===== rtl/ppd_pkg.sv =====
package ppd_pkg;

    // Field widths of one segment.
    localparam int START_W  = 12;
    localparam int SLOPE_W  = 16;
    localparam int OFFSET_W = 10;
    localparam int PIXEL_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    // Slopes are Q4.12, so one unit of slope is a shift by twelve.
    localparam int SLOPE_FRAC = 12;

    // Segments held in the packed registers, and segments per register.
    localparam int PACKED_SEGMENTS = 6;
    localparam int SEGS_PER_REG    = 3;

    // Segment index width; covers every allowed segment count plus one.
    localparam int SEG_W = 4;

    // Default parameter values.
    localparam int DEF_MAX_SEGMENTS  = 6;
    localparam int DEF_OUTPUT_LIMIT  = 4095;
    localparam int DEF_FRACTION_BITS = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STARTS_LOW  = 3'd0,
        REG_STARTS_HIGH = 3'd1,
        REG_SLOPES_LOW  = 3'd2,
        REG_SLOPES_HIGH = 3'd3,
        REG_OFFS_LOW    = 3'd4,
        REG_OFFS_HIGH   = 3'd5,
        REG_SEG_COUNT   = 3'd6
    } t_reg_idx;

    // One decompanding segment, with a zero slope already read as one.
    typedef struct packed {
        logic [START_W-1:0]         start;
        logic [SLOPE_W-1:0]         slope;
        logic signed [OFFSET_W-1:0] offset;
    } t_seg;

    // An item travelling down the segment search chain.
    typedef struct packed {
        logic               valid;
        logic [PIXEL_W-1:0] pixel;
        logic [SEG_W-1:0]   seg;
        logic               search;
        logic               bypass;
    } t_token;

endpackage

// ===== rtl/ppd_cell.sv =====
module ppd_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ppd_pkg::t_token           i_tok,
    input  ppd_pkg::t_seg             i_seg,
    input  logic [ppd_pkg::START_W-1:0] i_next_start,
    input  logic                      i_next_ok,
    output ppd_pkg::t_token           o_tok
);
    import ppd_pkg::*;

    logic signed [29:0] lhs;
    logic [27:0]        rhs;
    logic               go;
    ppd_pkg::t_token    r_tok;

    // Inverse of this segment's line reaching the next start moves the item on.
    assign lhs = ($signed({22'd0, i_tok.pixel}) - 30'(i_seg.offset)) <<< SLOPE_FRAC;
    assign rhs = 28'(i_next_start) * 28'(i_seg.slope);
    assign go  = i_tok.search && i_next_ok && (lhs >= $signed({2'b00, rhs}));

    // Hand the item to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.pixel  <= i_tok.pixel;
        r_tok.seg    <= i_tok.seg + SEG_W'(go);
        r_tok.search <= go;
        r_tok.bypass <= i_tok.bypass;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/ppd_finish.sv =====
module ppd_finish #(
    parameter int OUTPUT_LIMIT  = ppd_pkg::DEF_OUTPUT_LIMIT,
    parameter int FRACTION_BITS = ppd_pkg::DEF_FRACTION_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppd_pkg::t_token             i_tok,
    input  ppd_pkg::t_seg               i_cur,
    input  ppd_pkg::t_seg               i_nxt,
    input  logic                        i_has_next,
    output logic                        o_loaded,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ppd_pkg::VALUE_W-1:0] o_value
);
    import ppd_pkg::*;

    localparam int VW = 52;
    localparam int MA = 18;
    localparam int MB = 34;
    localparam int CW = $clog2(VW + 1);
    localparam int LIMIT_FULL = OUTPUT_LIMIT << FRACTION_BITS;
    localparam int LIMIT_Q = (LIMIT_FULL > 65535) ? 65535 : LIMIT_FULL;

    typedef enum logic [11:0] {
        F_IDLE = 12'b0000_0000_0001,
        F_M0   = 12'b0000_0000_0010,
        F_M1   = 12'b0000_0000_0100,
        F_M2   = 12'b0000_0000_1000,
        F_M3   = 12'b0000_0001_0000,
        F_M4   = 12'b0000_0010_0000,
        F_M5   = 12'b0000_0100_0000,
        F_M6   = 12'b0000_1000_0000,
        F_M7   = 12'b0001_0000_0000,
        F_DIV  = 12'b0010_0000_0000,
        F_SAT  = 12'b0100_0000_0000,
        F_DONE = 12'b1000_0000_0000
    } t_fstate;

    t_fstate                 r_state;
    logic [PIXEL_W-1:0]      r_pixel;
    logic                    r_has_next;
    t_seg                    r_cur;
    t_seg                    r_nxt;
    logic signed [VW-1:0]    r_un;
    logic signed [VW-1:0]    r_ln;
    logic signed [VW-1:0]    r_nn;
    logic signed [VW-1:0]    r_prod;
    logic                    r_clamp;
    logic                    r_test;
    logic                    r_snap;
    logic [VW-1:0]           r_quo;
    logic [MA-1:0]           r_rem;
    logic [MA-1:0]           r_div;
    logic [CW-1:0]           r_cnt;
    logic [VALUE_W-1:0]      r_res;
    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out;

    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [VW-1:0]    mul_p;
    logic signed [VW-1:0]    s_v;
    logic signed [VW-1:0]    d_v;
    logic signed [VW-1:0]    lower;
    logic signed [VW-1:0]    upper;
    logic signed [VW-1:0]    ln_c;
    logic signed [VW-1:0]    sum;
    logic signed [VW-1:0]    un0;
    logic signed [VW-1:0]    ln0;
    logic [VW-1:0]           pass;
    logic [MA:0]             rem_sh;
    logic                    qbit;
    logic                    load;

    // Current slope, and the slope scaled by one unit of the Q4.12 format.
    assign s_v = $signed(VW'(r_cur.slope));
    assign d_v = s_v <<< SLOPE_FRAC;

    // Shared multiplier; each step feeds it one pair of operands.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            F_M0: begin
                mul_a = $signed(MA'(r_cur.slope));
                mul_b = $signed(MB'(OUTPUT_LIMIT));
            end
            F_M1: begin
                mul_a = $signed(MA'(r_cur.slope));
                mul_b = $signed(MB'(r_nxt.start));
            end
            F_M2: begin
                mul_a = $signed(MA'(r_nxt.slope));
                mul_b = r_un[MB-1:0];
            end
            F_M3: begin
                mul_a = MA'(r_nxt.offset);
                mul_b = $signed(MB'(r_cur.slope));
            end
            F_M4: begin
                mul_a = $signed(MA'(r_cur.slope));
                mul_b = $signed(MB'(r_pixel));
            end
            F_M5: begin
                mul_a = $signed(MA'(r_cur.slope));
                mul_b = $signed(MB'(r_nxt.start)) - MB'(1);
            end
            F_M6: begin
                mul_a = $signed(MA'(r_cur.slope));
                mul_b = $signed(MB'(r_cur.start));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Bin edges of a new item, both scaled by the slope.
    assign un0 = (($signed(VW'(i_tok.pixel)) + VW'(1) - VW'(i_cur.offset)) <<< SLOPE_FRAC)
                 - $signed(VW'(i_cur.slope));
    assign ln0 = ($signed(VW'(i_tok.pixel)) - VW'(i_cur.offset)) <<< SLOPE_FRAC;
    assign pass = VW'(i_tok.pixel) << FRACTION_BITS;

    // Window of the truncated next-segment code that equals the pixel.
    assign lower = (r_pixel == '0) ? (VW'(1) - d_v) : (r_prod <<< SLOPE_FRAC);
    assign upper = (r_prod <<< SLOPE_FRAC) + d_v;

    // Lower edge clamped up to the segment start, then the sum of the edges.
    assign ln_c = (r_ln < r_prod) ? r_prod : r_ln;
    assign sum  = r_un + ln_c;

    // One restoring division step.
    assign rem_sh = {r_rem, r_quo[VW-1]};
    assign qbit   = rem_sh >= {1'b0, r_div};

    assign load = (r_state == F_DONE) && (!r_out_valid || i_ready);

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_tok.valid) begin
                        r_state <= i_tok.bypass ? F_DONE : F_M0;
                    end
                end
                F_M0: r_state <= F_M1;
                F_M1: r_state <= F_M2;
                F_M2: r_state <= F_M3;
                F_M3: r_state <= F_M4;
                F_M4: r_state <= F_M5;
                F_M5: r_state <= F_M6;
                F_M6: r_state <= F_M7;
                F_M7: r_state <= (sum <= 0) ? F_DONE : F_DIV;
                F_DIV: begin
                    if (r_cnt == CW'(VW - 1)) begin
                        r_state <= F_SAT;
                    end
                end
                F_SAT: r_state <= F_DONE;
                F_DONE: begin
                    if (load) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Datapath of each step.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            F_IDLE: begin
                r_pixel    <= i_tok.pixel;
                r_has_next <= i_has_next;
                r_cur      <= i_cur;
                r_nxt      <= i_nxt;
                r_un       <= un0;
                r_ln       <= ln0;
                r_res      <= (pass > VW'(LIMIT_Q)) ? VALUE_W'(LIMIT_Q) : pass[VALUE_W-1:0];
            end
            F_M1: begin
                r_clamp <= r_un > r_prod;
                if (r_un > r_prod) begin
                    r_un <= r_prod;
                end
            end
            F_M2: r_test <= !r_clamp && r_has_next && (r_un >= r_prod);
            F_M3: r_nn <= r_prod;
            F_M4: r_nn <= r_nn + (r_prod <<< SLOPE_FRAC);
            F_M5: r_snap <= r_test && !((r_nn >= lower) && (r_nn < upper));
            F_M6: begin
                if (r_snap) begin
                    r_un <= r_prod;
                end
            end
            F_M7: begin
                r_res <= '0;
                r_quo <= VW'((sum <<< FRACTION_BITS) + s_v);
                r_rem <= '0;
                r_div <= MA'({r_cur.slope, 1'b0});
                r_cnt <= '0;
            end
            F_DIV: begin
                r_rem <= qbit ? MA'(rem_sh - {1'b0, r_div}) : rem_sh[MA-1:0];
                r_quo <= {r_quo[VW-2:0], qbit};
                r_cnt <= r_cnt + CW'(1);
            end
            F_SAT: begin
                r_res <= (r_quo > VW'(LIMIT_Q)) ? VALUE_W'(LIMIT_Q) : r_quo[VALUE_W-1:0];
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // Output register; a new item may enter the chain while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out <= r_res;
        end
    end

    assign o_loaded = load;
    assign o_valid  = r_out_valid;
    assign o_value  = r_out;

endmodule

// ===== rtl/piecewise_pixel_decompander.sv =====
// Channel   Direction  Handshake            Payload
// pixel     in         i_valid / o_ready    i_coded_pixel (8 bits)
// result    out        o_valid / i_ready    o_restored_value (16 bits, 4 fraction bits)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item at a time. An item walks the segment search chain, one cell a cycle;
// then the finishing unit takes eight steps on its shared multiplier, runs the
// bit-serial divider and saturates. The divider and the saturation are skipped
// when the mean is not positive, and all of the finishing steps are skipped
// below the first start.
// The output register lets the next item enter while a result waits.
// Reset is synchronous and active low; it clears control state and the configuration registers.
module piecewise_pixel_decompander #(
    parameter int MAX_SEGMENTS  = ppd_pkg::DEF_MAX_SEGMENTS,
    parameter int OUTPUT_LIMIT  = ppd_pkg::DEF_OUTPUT_LIMIT,
    parameter int FRACTION_BITS = ppd_pkg::DEF_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ppd_pkg::PIXEL_W-1:0]   i_coded_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ppd_pkg::VALUE_W-1:0]   o_restored_value,
    input  logic                          i_cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ppd_pkg::*;

    localparam int NCAP = (MAX_SEGMENTS < PACKED_SEGMENTS) ? MAX_SEGMENTS : PACKED_SEGMENTS;
    localparam int NSEG = 2 ** SEG_W;

    logic [35:0] r_starts_low;
    logic [35:0] r_starts_high;
    logic [47:0] r_slopes_low;
    logic [47:0] r_slopes_high;
    logic [29:0] r_offs_low;
    logic [29:0] r_offs_high;
    logic [2:0]  r_seg_count;
    logic        r_busy;

    logic [2:0]  n_eff;
    t_seg        segs [NSEG];
    t_token      toks [MAX_SEGMENTS + 1];
    t_token      in_tok;
    logic [SEG_W-1:0] k_end;
    logic [SEG_W-1:0] k_next;
    logic        has_next;
    logic        loaded;
    logic        accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_starts_low  <= '0;
            r_starts_high <= '0;
            r_slopes_low  <= '0;
            r_slopes_high <= '0;
            r_offs_low    <= '0;
            r_offs_high   <= '0;
            r_seg_count   <= 3'(PACKED_SEGMENTS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STARTS_LOW:  r_starts_low  <= i_cfg_data[35:0];
                REG_STARTS_HIGH: r_starts_high <= i_cfg_data[35:0];
                REG_SLOPES_LOW:  r_slopes_low  <= i_cfg_data[47:0];
                REG_SLOPES_HIGH: r_slopes_high <= i_cfg_data[47:0];
                REG_OFFS_LOW:    r_offs_low    <= i_cfg_data[29:0];
                REG_OFFS_HIGH:   r_offs_high   <= i_cfg_data[29:0];
                REG_SEG_COUNT:   r_seg_count   <= i_cfg_data[2:0];
                default:         r_seg_count   <= r_seg_count;
            endcase
        end
    end

    // Segment count in effect: at least one, at most what is built and packed.
    always_comb begin
        n_eff = r_seg_count;
        if (r_seg_count == 3'd0) begin
            n_eff = 3'd1;
        end else if (32'(r_seg_count) > NCAP) begin
            n_eff = 3'(NCAP);
        end
    end

    // Unpack the segments; unpacked places read as zero with a slope of one.
    for (genvar gi = 0; gi < NSEG; gi++) begin : g_seg
        if (gi < SEGS_PER_REG) begin : g_low
            assign segs[gi].start  = r_starts_low[START_W*gi +: START_W];
            assign segs[gi].slope  = (r_slopes_low[SLOPE_W*gi +: SLOPE_W] == '0) ?
                                     SLOPE_W'(1) : r_slopes_low[SLOPE_W*gi +: SLOPE_W];
            assign segs[gi].offset = $signed(r_offs_low[OFFSET_W*gi +: OFFSET_W]);
        end else if (gi < PACKED_SEGMENTS) begin : g_high
            localparam int J = gi - SEGS_PER_REG;
            assign segs[gi].start  = r_starts_high[START_W*J +: START_W];
            assign segs[gi].slope  = (r_slopes_high[SLOPE_W*J +: SLOPE_W] == '0) ?
                                     SLOPE_W'(1) : r_slopes_high[SLOPE_W*J +: SLOPE_W];
            assign segs[gi].offset = $signed(r_offs_high[OFFSET_W*J +: OFFSET_W]);
        end else begin : g_none
            assign segs[gi].start  = '0;
            assign segs[gi].slope  = SLOPE_W'(1);
            assign segs[gi].offset = '0;
        end
    end

    // Input handshake: one item in flight until its result is registered.
    assign o_ready = !r_busy;
    assign accept  = i_valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (loaded) begin
            r_busy <= 1'b0;
        end
    end

    // An item below the first start passes straight through.
    assign in_tok.valid  = accept;
    assign in_tok.pixel  = i_coded_pixel;
    assign in_tok.seg    = '0;
    assign in_tok.bypass = 12'(i_coded_pixel) < segs[0].start;
    assign in_tok.search = !in_tok.bypass;
    assign toks[0]       = in_tok;

    // Segment search chain; cell i decides whether the item moves past segment i.
    for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
        ppd_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (toks[gi]),
            .i_seg       (segs[gi]),
            .i_next_start(segs[gi + 1].start),
            .i_next_ok   (32'(n_eff) > (gi + 1)),
            .o_tok       (toks[gi + 1])
        );
    end

    // Parameters of the chosen segment and the one after it.
    assign k_end    = toks[MAX_SEGMENTS].seg;
    assign k_next   = k_end + SEG_W'(1);
    assign has_next = k_next < SEG_W'(n_eff);

    ppd_finish #(
        .OUTPUT_LIMIT (OUTPUT_LIMIT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_finish (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok     (toks[MAX_SEGMENTS]),
        .i_cur     (segs[k_end]),
        .i_nxt     (segs[k_next]),
        .i_has_next(has_next),
        .o_loaded  (loaded),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_restored_value)
    );

endmodule
